// File: sv/spf_pkg.sv
// Shared types, widths and register codes for the spin period fire window block.
package spf_pkg;

   localparam int POS_BITS  = 16;
   localparam int TICK_BITS = 16;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam int THRESH_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int LIMIT_BITS  = 16;
   localparam int OFFSET_BITS = 16;
   localparam int WIDTH_BITS  = 16;

   localparam int JUMP_BITS     = POS_BITS + 3;
   localparam int JUMP_CMP_BITS = (JUMP_BITS > THRESH_BITS) ? JUMP_BITS : THRESH_BITS;
   localparam int PROD_BITS     = TICK_BITS + FRAC_BITS;
   localparam int LOST_CMP_BITS = (TICK_BITS > LIMIT_BITS) ? TICK_BITS : LIMIT_BITS;
   localparam int FIRE_BITS     = ((TICK_BITS > OFFSET_BITS) ? TICK_BITS : OFFSET_BITS) + 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_JUMP_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD_FRACTION = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOST_LIMIT      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRE_OFFSET     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRE_WIDTH      = 3'd4;

   localparam logic [THRESH_BITS-1:0] JUMP_THRESHOLD_RESET  = 16'd300;
   localparam logic [FRAC_BITS-1:0]   PERIOD_FRACTION_RESET = 8'd51;
   localparam logic [LIMIT_BITS-1:0]  LOST_LIMIT_RESET      = 16'd1000;
   localparam logic [OFFSET_BITS-1:0] FIRE_OFFSET_RESET     = 16'd0;
   localparam logic [WIDTH_BITS-1:0]  FIRE_WIDTH_RESET      = 16'd0;

   typedef struct packed {
      logic                       target_seen;
      logic signed [POS_BITS-1:0] pos_x;
      logic signed [POS_BITS-1:0] pos_y;
      logic signed [POS_BITS-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic                       fire_enable;
      logic                       spin_detected;
      logic [TICK_BITS-1:0]       spin_period;
      logic signed [POS_BITS-1:0] locked_x;
      logic signed [POS_BITS-1:0] locked_y;
      logic signed [POS_BITS-1:0] locked_z;
   } rsp_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0]       jump_threshold;
      logic [FRAC_BITS-1:0]         period_fraction;
      logic [LIMIT_BITS-1:0]        lost_limit;
      logic [OFFSET_BITS-1:0]       fire_offset;
      logic signed [WIDTH_BITS-1:0] fire_width;
   } cfg_type;

endpackage

// File: sv/spf_csr.sv
// Configuration register file for the spin period fire window block.
module spf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [spf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [spf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output spf_pkg::cfg_type                    cfg
);

   spf_pkg::cfg_type cfg_ff;
   spf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            spf_pkg::CSR_JUMP_THRESHOLD: begin
               cfg_in.jump_threshold = csr_wdata[spf_pkg::THRESH_BITS-1:0];
            end
            spf_pkg::CSR_PERIOD_FRACTION: begin
               cfg_in.period_fraction = csr_wdata[spf_pkg::FRAC_BITS-1:0];
            end
            spf_pkg::CSR_LOST_LIMIT: begin
               cfg_in.lost_limit = csr_wdata[spf_pkg::LIMIT_BITS-1:0];
            end
            spf_pkg::CSR_FIRE_OFFSET: begin
               cfg_in.fire_offset = csr_wdata[spf_pkg::OFFSET_BITS-1:0];
            end
            spf_pkg::CSR_FIRE_WIDTH: begin
               cfg_in.fire_width = csr_wdata[spf_pkg::WIDTH_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jump_threshold  <= spf_pkg::JUMP_THRESHOLD_RESET;
         cfg_ff.period_fraction <= spf_pkg::PERIOD_FRACTION_RESET;
         cfg_ff.lost_limit      <= spf_pkg::LOST_LIMIT_RESET;
         cfg_ff.fire_offset     <= spf_pkg::FIRE_OFFSET_RESET;
         cfg_ff.fire_width      <= spf_pkg::FIRE_WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/spf_core.sv
// Spin tracking state and the single-pass update that produces one result per request.
module spf_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  spf_pkg::req_type req,
   input  spf_pkg::cfg_type cfg,
   output spf_pkg::rsp_type rsp
);

   localparam int PB = spf_pkg::POS_BITS;
   localparam int TB = spf_pkg::TICK_BITS;

   logic [TB-1:0]        tick_count_ff, tick_count_in;
   logic [TB-1:0]        period_ff, period_in;
   logic                 spin_ff, spin_in;
   logic signed [PB-1:0] last_pos_ff [3];
   logic signed [PB-1:0] last_pos_in [3];
   logic signed [PB-1:0] locked_pos_ff [3];
   logic signed [PB-1:0] locked_pos_in [3];

   logic signed [PB-1:0]                        pos [3];
   logic [PB:0]                                 axis_jump [3];
   logic [spf_pkg::JUMP_BITS-1:0]               jump_sum;
   logic                                        big_jump;
   logic [spf_pkg::PROD_BITS-1:0]               frac_prod;
   logic [spf_pkg::PROD_BITS-1:0]               tick_scaled;
   logic                                        early;
   logic                                        switch_event;
   logic [TB-1:0]                               tick_inc;
   logic [TB-1:0]                               tick_evt;
   logic                                        spin_evt;
   logic                                        lost;
   logic signed [spf_pkg::FIRE_BITS-1:0]        remain;
   logic signed [spf_pkg::FIRE_BITS-1:0]        win_lo;
   logic signed [spf_pkg::FIRE_BITS-1:0]        win_hi;
   logic                                        fire;

   function automatic logic [PB:0] abs_diff(logic signed [PB-1:0] a, logic signed [PB-1:0] b);
      logic signed [PB:0] d;
      d = (PB+1)'(a) - (PB+1)'(b);
      return d[PB] ? (PB+1)'(-d) : (PB+1)'(d);
   endfunction

   always_comb begin
      pos[0] = req.pos_x;
      pos[1] = req.pos_y;
      pos[2] = req.pos_z;
      for (int i = 0; i < 3; i++) begin
         axis_jump[i] = abs_diff(pos[i], last_pos_ff[i]);
      end
      jump_sum = spf_pkg::JUMP_BITS'(axis_jump[0]) + spf_pkg::JUMP_BITS'(axis_jump[1])
               + spf_pkg::JUMP_BITS'(axis_jump[2]);
      big_jump = spf_pkg::JUMP_CMP_BITS'(jump_sum)
               > spf_pkg::JUMP_CMP_BITS'(cfg.jump_threshold);

      tick_inc    = tick_count_ff + TB'(1);
      frac_prod   = spf_pkg::PROD_BITS'(cfg.period_fraction) * spf_pkg::PROD_BITS'(period_ff);
      tick_scaled = {tick_inc, {spf_pkg::FRAC_BITS{1'b0}}};
      early       = (tick_inc != '0) && (tick_scaled <= frac_prod);

      switch_event = req.target_seen && (big_jump || early);
      tick_evt     = switch_event ? '0 : tick_inc;
      period_in    = switch_event ? tick_inc : period_ff;
      spin_evt     = spin_ff || switch_event;

      for (int i = 0; i < 3; i++) begin
         last_pos_in[i]   = req.target_seen ? pos[i] : last_pos_ff[i];
         locked_pos_in[i] = (switch_event && spin_ff) ? pos[i] : locked_pos_ff[i];
      end

      lost = spf_pkg::LOST_CMP_BITS'(tick_evt) > spf_pkg::LOST_CMP_BITS'(cfg.lost_limit);
      spin_in       = lost ? 1'b0 : spin_evt;
      tick_count_in = lost ? '0 : tick_evt;

      remain = spf_pkg::FIRE_BITS'(period_in) - spf_pkg::FIRE_BITS'(tick_evt);
      win_lo = spf_pkg::FIRE_BITS'(cfg.fire_offset);
      win_hi = win_lo + spf_pkg::FIRE_BITS'(cfg.fire_width);
      fire   = !lost && spin_evt && (remain > win_lo) && (remain < win_hi);
   end

   always_comb begin
      rsp.fire_enable   = fire;
      rsp.spin_detected = spin_in;
      rsp.spin_period   = period_in;
      rsp.locked_x      = locked_pos_in[0];
      rsp.locked_y      = locked_pos_in[1];
      rsp.locked_z      = locked_pos_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         period_ff     <= '0;
         spin_ff       <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            last_pos_ff[i]   <= '0;
            locked_pos_ff[i] <= '0;
         end
      end else if (advance) begin
         tick_count_ff <= tick_count_in;
         period_ff     <= period_in;
         spin_ff       <= spin_in;
         for (int i = 0; i < 3; i++) begin
            last_pos_ff[i]   <= last_pos_in[i];
            locked_pos_ff[i] <= locked_pos_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tick_count_ff) && $stable(period_ff) && $stable(spin_ff))
      else $error("spin state changed without a request");

   a_lock_needs_spin: assert property (@(posedge clock) disable iff (reset)
      advance && !spin_ff |=> $stable(locked_pos_ff[0]) && $stable(locked_pos_ff[1])
         && $stable(locked_pos_ff[2]))
      else $error("position latched before spin was armed");

   a_new_period_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && (period_in != period_ff) |=> tick_count_ff == '0)
      else $error("tick count not restarted on a new period");

   a_fire_needs_spin: assert property (@(posedge clock) disable iff (reset)
      advance && rsp.fire_enable |-> rsp.spin_detected)
      else $error("fire enabled without spin");
`endif

endmodule

// File: sv/spin_period_fire_window_top.sv
// Top level of the spin period fire window block: request register, core and result register.
//
// Each request is one control tick. The block takes one request per clock while the
// result side keeps up. The request is captured in an input register at acceptance,
// the tick, period, spin and position state is updated in a single pass of compare
// and add logic with one 8 by 16 bit multiply, and the result lands in an output
// register when the core advances, which raises rsp_valid until the result is taken.
// Stalls on the result side back up through the input register, so throughput
// stays at one request per clock whenever the result channel keeps up.
// Configuration writes take effect on the next clock.
module spin_period_fire_window_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  spf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output spf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_en,
   input  logic [spf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [spf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   spf_pkg::cfg_type cfg;
   spf_pkg::req_type in_data_ff;
   logic             in_valid_ff, in_valid_in;
   spf_pkg::rsp_type rsp_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   spf_pkg::rsp_type core_rsp;
   logic             advance;
   logic             req_accept;

   spf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   spf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (core_rsp)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
